>>> hw/rtl/csgs_pkg.sv
// Shared types and constants for the column scan glyph segmenter.
// Field widths, register indexes, reset values and the result record.
// No dependencies.
package csgs_pkg;

  localparam int PIXEL_W     = 8;
  localparam int THR_W       = 8;
  localparam int SIZE_W      = 11;
  localparam int OUT_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  localparam int DEF_MAX_COLUMN_LENGTH = 1024;
  localparam int DEF_MAX_COLUMNS       = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT   = 2'd2;

  localparam logic [THR_W-1:0]  RST_DARK_THRESHOLD = 8'd127;
  localparam logic [SIZE_W-1:0] RST_COLUMN_LENGTH  = 11'd1024;
  localparam logic [SIZE_W-1:0] RST_COLUMN_COUNT   = 11'd1024;

  typedef struct packed {
    logic [OUT_W-1:0] left_column;
    logic [OUT_W-1:0] right_column;
    logic [OUT_W-1:0] top_row;
    logic [OUT_W-1:0] bottom_row;
    logic             has_bottom;
  } box_t;

endpackage

>>> hw/rtl/csgs_core.sv
// Scan state and per-pixel update of the glyph segmenter.
// Tracks row/column position and the open shape; flags a box at column end.
// Depends on csgs_pkg.
module csgs_core #(
  parameter int MAX_COLUMN_LENGTH = csgs_pkg::DEF_MAX_COLUMN_LENGTH,
  parameter int MAX_COLUMNS       = csgs_pkg::DEF_MAX_COLUMNS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [csgs_pkg::PIXEL_W-1:0] pixel,
  input  logic [csgs_pkg::THR_W-1:0]   dark_threshold,
  input  logic [csgs_pkg::SIZE_W-1:0]  column_length,
  input  logic [csgs_pkg::SIZE_W-1:0]  column_count,
  output logic                         emit,
  output csgs_pkg::box_t               box
);

  localparam int ROW_W  = $clog2(MAX_COLUMN_LENGTH);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int LEN_W  = $clog2(MAX_COLUMN_LENGTH + 1);
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int LEXT_W = ((LEN_W > csgs_pkg::SIZE_W) ? LEN_W : csgs_pkg::SIZE_W) + 1;
  localparam int CEXT_W = ((CNT_W > csgs_pkg::SIZE_W) ? CNT_W : csgs_pkg::SIZE_W) + 1;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             prev_dark_r, prev_dark_nxt;
  logic             had_ink_r, had_ink_nxt;
  logic             open_r, open_nxt;
  logic [COL_W-1:0] left_r, left_nxt;
  logic             top_seen_r, top_seen_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic             bot_seen_r, bot_seen_nxt;
  logic [ROW_W-1:0] bot_r, bot_nxt;

  logic              dark;
  logic [LEXT_W-1:0] len_ext, len_eff;
  logic [CEXT_W-1:0] cnt_ext, cnt_eff;
  logic              col_end, img_end;
  logic              top_seen_u, bot_seen_u, had_ink_u;
  logic [ROW_W-1:0]  top_u, bot_u;

  assign dark    = pixel < dark_threshold;
  assign len_ext = LEXT_W'(column_length);
  assign cnt_ext = CEXT_W'(column_count);

  always_comb begin
    if (len_ext == '0) begin
      len_eff = LEXT_W'(1);
    end else if (len_ext > LEXT_W'(MAX_COLUMN_LENGTH)) begin
      len_eff = LEXT_W'(MAX_COLUMN_LENGTH);
    end else begin
      len_eff = len_ext;
    end
    if (cnt_ext == '0) begin
      cnt_eff = CEXT_W'(1);
    end else if (cnt_ext > CEXT_W'(MAX_COLUMNS)) begin
      cnt_eff = CEXT_W'(MAX_COLUMNS);
    end else begin
      cnt_eff = cnt_ext;
    end
  end

  assign col_end = (LEXT_W'(row_r) + LEXT_W'(1)) >= len_eff;
  assign img_end = (CEXT_W'(col_r) + CEXT_W'(1)) >= cnt_eff;

  always_comb begin
    top_seen_u = top_seen_r;
    top_u      = top_r;
    bot_seen_u = bot_seen_r;
    bot_u      = bot_r;
    had_ink_u  = had_ink_r;
    if (dark) begin
      if (!top_seen_r || (row_r < top_r)) begin
        top_u      = row_r;
        top_seen_u = 1'b1;
      end
      had_ink_u = 1'b1;
    end else if ((row_r != '0) && prev_dark_r && (!bot_seen_r || (row_r > bot_r))) begin
      bot_u      = row_r;
      bot_seen_u = 1'b1;
    end
  end

  assign emit = col_end && !had_ink_u && open_r;

  always_comb begin
    box.left_column  = csgs_pkg::OUT_W'(left_r);
    box.right_column = csgs_pkg::OUT_W'(col_r);
    box.top_row      = top_seen_u ? csgs_pkg::OUT_W'(top_u) : '0;
    box.bottom_row   = bot_seen_u ? csgs_pkg::OUT_W'(bot_u) : '0;
    box.has_bottom   = bot_seen_u;
  end

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    prev_dark_nxt = dark;
    had_ink_nxt   = had_ink_u;
    open_nxt      = open_r;
    left_nxt      = left_r;
    top_seen_nxt  = top_seen_u;
    top_nxt       = top_u;
    bot_seen_nxt  = bot_seen_u;
    bot_nxt       = bot_u;
    if (col_end) begin
      if (had_ink_u) begin
        if (!open_r) begin
          left_nxt = col_r;
          open_nxt = 1'b1;
        end
      end else if (open_r) begin
        open_nxt     = 1'b0;
        left_nxt     = '0;
        top_seen_nxt = 1'b0;
        top_nxt      = '0;
        bot_seen_nxt = 1'b0;
        bot_nxt      = '0;
      end
      had_ink_nxt   = 1'b0;
      prev_dark_nxt = 1'b0;
      row_nxt       = '0;
      if (img_end) begin
        col_nxt      = '0;
        open_nxt     = 1'b0;
        left_nxt     = '0;
        top_seen_nxt = 1'b0;
        top_nxt      = '0;
        bot_seen_nxt = 1'b0;
        bot_nxt      = '0;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end else begin
      row_nxt = row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      prev_dark_r <= 1'b0;
      had_ink_r   <= 1'b0;
      open_r      <= 1'b0;
      left_r      <= '0;
      top_seen_r  <= 1'b0;
      top_r       <= '0;
      bot_seen_r  <= 1'b0;
      bot_r       <= '0;
    end else if (step) begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      prev_dark_r <= prev_dark_nxt;
      had_ink_r   <= had_ink_nxt;
      open_r      <= open_nxt;
      left_r      <= left_nxt;
      top_seen_r  <= top_seen_nxt;
      top_r       <= top_nxt;
      bot_seen_r  <= bot_seen_nxt;
      bot_r       <= bot_nxt;
    end
  end

  a_open_has_top: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> top_seen_r)
    else $error("open shape without a top row");

  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && emit) |=> (!open_r && !top_seen_r && !bot_seen_r))
    else $error("shape state not cleared after box");

  a_bottom_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    bot_seen_r |-> (bot_r != '0))
    else $error("bottom edge recorded at row zero");

  a_ink_column_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (step && dark) |-> !emit)
    else $error("box emitted on an ink pixel");

endmodule

>>> hw/rtl/column_scan_glyph_segmenter_unit.sv
// Top level of the column scan glyph segmenter: config registers, pixel
// input register and box output register around csgs_core.
// Depends on csgs_pkg and csgs_core.
//
//   channel | direction | beat
//   in_     | input     | one pixel, column-major order
//   out_    | output    | one glyph bounding box
//   cfg_    | input     | register index and write data
//
// One pixel per cycle while out_ is not stalled. An accepted pixel waits in the
// single-entry input register and updates the scan state when it steps the
// core; its box, if any, shows from the output register on out_ at that edge.
// Synchronous active-low reset clears scan state and loads register defaults.
// A stalled output holds its box; the input register keeps taking pixels
// until it is full behind the stalled box.
module column_scan_glyph_segmenter_unit #(
  parameter int MAX_COLUMN_LENGTH = csgs_pkg::DEF_MAX_COLUMN_LENGTH,
  parameter int MAX_COLUMNS       = csgs_pkg::DEF_MAX_COLUMNS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [csgs_pkg::PIXEL_W-1:0]    in_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [csgs_pkg::OUT_W-1:0]      out_left_column,
  output logic [csgs_pkg::OUT_W-1:0]      out_right_column,
  output logic [csgs_pkg::OUT_W-1:0]      out_top_row,
  output logic [csgs_pkg::OUT_W-1:0]      out_bottom_row,
  output logic                            out_has_bottom,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [csgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csgs_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [csgs_pkg::THR_W-1:0]   thr_r;
  logic [csgs_pkg::SIZE_W-1:0]  len_r;
  logic [csgs_pkg::SIZE_W-1:0]  cnt_r;

  logic                         pix_valid_r;
  logic [csgs_pkg::PIXEL_W-1:0] pix_r;
  logic                         out_valid_r, out_valid_nxt;
  csgs_pkg::box_t               box_r;

  logic                         step;
  logic                         emit;
  csgs_pkg::box_t               box;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= csgs_pkg::RST_DARK_THRESHOLD;
      len_r <= csgs_pkg::RST_COLUMN_LENGTH;
      cnt_r <= csgs_pkg::RST_COLUMN_COUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        csgs_pkg::REG_DARK_THRESHOLD: thr_r <= cfg_data[csgs_pkg::THR_W-1:0];
        csgs_pkg::REG_COLUMN_LENGTH:  len_r <= cfg_data[csgs_pkg::SIZE_W-1:0];
        csgs_pkg::REG_COLUMN_COUNT:   cnt_r <= cfg_data[csgs_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign step     = pix_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !pix_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_ready) begin
      pix_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r <= in_pixel;
    end
  end

  csgs_core #(
    .MAX_COLUMN_LENGTH (MAX_COLUMN_LENGTH),
    .MAX_COLUMNS       (MAX_COLUMNS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .pixel          (pix_r),
    .dark_threshold (thr_r),
    .column_length  (len_r),
    .column_count   (cnt_r),
    .emit           (emit),
    .box            (box)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      box_r <= box;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_column  = box_r.left_column;
  assign out_right_column = box_r.right_column;
  assign out_top_row      = box_r.top_row;
  assign out_bottom_row   = box_r.bottom_row;
  assign out_has_bottom   = box_r.has_bottom;

endmodule
